// ===== hdl/ffba_pkg.sv =====
// ============================================================================
// ffba_pkg: shared types and constants for the first-fit block allocator
// Field widths, request and status codes, and the queue entry layout.
// ============================================================================
package ffba_pkg;

  localparam int CAPACITY     = 1024;
  localparam int INITIAL_SIZE = 8;
  localparam int MAX_BLOCK    = 32;
  localparam int AW           = $clog2(CAPACITY);     // slot index width
  localparam int CW           = AW + 1;               // count width
  localparam int LW           = 6;                    // length field width
  localparam int DW           = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADPOS  = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  // One classified request passed from the front to the back.
  typedef struct packed {
    req_t           req;
    logic [LW-1:0]  len;
    logic [DW-1:0]  data;
    logic [AW-1:0]  pos;
  } cmd_t;

  // One result word.
  typedef struct packed {
    status_t        status;
    logic [AW-1:0]  block_position;
    logic [DW-1:0]  word_out;
    logic [CW-1:0]  used_count;
    logic [CW-1:0]  reserved_size;
    logic           last;
  } res_t;

endpackage

// ===== hdl/ffba_front.sv =====
// ============================================================================
// ffba_front: request intake and command queue
// Buffer commands from the top level in a short FIFO.
// ============================================================================
module ffba_front
  import ffba_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cmd_t          in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output cmd_t          q_cmd
);

  localparam int QD = 4;

  cmd_t         mem_r [QD];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;
  logic         push, pop;

  assign in_ready = (cnt_r != 3'(QD));
  assign q_valid  = (cnt_r != 3'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== hdl/ffba_back.sv =====
// ============================================================================
// ffba_back: allocator engine
// Execute commands against the slot memory, one at a time.
// ============================================================================
module ffba_back
  import ffba_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  output logic  q_ready,
  input  cmd_t  q_cmd,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  // one slot entry: header flag, occupied flag, data word
  localparam int EW = DW + 2;
  localparam int HB = DW + 1;
  localparam int OB = DW;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_GROW   = 9'b000001000,
    S_MARK   = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_CLEAR  = 9'b001000000,
    S_SHRINK = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t          state_r;
  logic [EW-1:0]   slot_mem [CAPACITY];
  logic [CW-1:0]   used_r, size_r;
  logic [AW-1:0]   fill_r;
  logic [LW-1:0]   pend_r;
  cmd_t            cmd_r;
  logic [CW-1:0]   p_r;       // candidate / block base
  logic [CW-1:0]   i_r;       // offset or sweep index
  logic [LW-1:0]   len_r;
  logic [EW-1:0]   rd_r;
  logic            rd_v_r;    // rd_r holds the entry at the current slot
  res_t            res_r;
  logic            res_v_r;
  logic [CW:0]     end_sum;
  logic [AW-1:0]   slot;
  logic [CW-1:0]   hlen;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [EW-1:0]   mem_wd;

  assign q_ready   = (state_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res       = res_r;
  assign slot      = AW'(p_r + i_r);
  assign end_sum   = (CW+1)'(p_r) + (CW+1)'(len_r);

  // single write port: clearing pass, data fill, block marking, block clearing
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot;
    mem_wd = '0;
    if (state_r == S_INIT) begin
      mem_we = 1'b1;
    end else if (state_r == S_IDLE && q_valid && q_ready && q_cmd.req == REQ_DATA &&
                 pend_r != '0) begin
      mem_we = 1'b1;
      mem_wa = fill_r;
      mem_wd = {1'b0, 1'b1, q_cmd.data};
    end else if (state_r == S_MARK) begin
      mem_we = 1'b1;
      mem_wd = (i_r == '0) ? {1'b1, 1'b1, DW'(len_r)} : {2'b01, {DW{1'b0}}};
    end else if (state_r == S_CLEAR && rd_v_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_r <= slot_mem[slot];
  end

  // header length clamp: stored length limited so the block stays inside the store
  always_comb begin
    hlen = CW'(rd_r[LW-1:0]);
    if ((CW+1)'(p_r) + (CW+1)'(hlen) >= (CW+1)'(CAPACITY))
      hlen = CW'(CAPACITY - 1) - p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      used_r  <= '0;
      size_r  <= CW'(INITIAL_SIZE);
      fill_r  <= '0;
      pend_r  <= '0;
      res_v_r <= 1'b0;
      rd_v_r  <= 1'b0;
      p_r     <= '0;
      i_r     <= '0;
      len_r   <= '0;
    end else begin
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      unique case (state_r)
        // clear the flags of every slot, one per cycle
        S_INIT: begin
          if (i_r == CW'(CAPACITY - 1)) begin
            i_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd_r          <= q_cmd;
            res_r.status   <= ST_OK;
            res_r.block_position <= '0;
            res_r.word_out <= '0;
            res_r.last     <= 1'b1;
            res_r.used_count    <= used_r;
            res_r.reserved_size <= size_r;
            case (q_cmd.req)
              REQ_ALLOC: begin
                if (pend_r != '0 || q_cmd.len == '0 || q_cmd.len > LW'(MAX_BLOCK)) begin
                  res_r.status <= ST_BUSY;
                  res_v_r      <= 1'b1;
                end else begin
                  len_r   <= q_cmd.len;
                  p_r     <= '0;
                  i_r     <= '0;
                  rd_v_r  <= 1'b0;
                  state_r <= S_SCAN;
                end
              end
              REQ_DATA: begin
                if (pend_r == '0) begin
                  res_r.status <= ST_BUSY;
                end else begin
                  fill_r <= fill_r + AW'(1);
                  pend_r <= pend_r - LW'(1);
                end
                res_v_r <= 1'b1;
              end
              default: begin
                if (pend_r != '0) begin
                  res_r.status <= ST_BUSY;
                  res_v_r      <= 1'b1;
                end else if (CW'(q_cmd.pos) >= size_r) begin
                  res_r.status <= ST_BADPOS;
                  res_v_r      <= 1'b1;
                end else begin
                  p_r     <= CW'(q_cmd.pos);
                  i_r     <= '0;
                  rd_v_r  <= 1'b0;
                  state_r <= S_CHECK;
                end
              end
            endcase
          end
        end
        // walk candidates: fetch a slot, then test it
        S_SCAN: begin
          if (end_sum >= (CW+1)'(CAPACITY)) begin
            res_r.status <= ST_NOSPACE;
            res_v_r      <= 1'b1;
            state_r      <= S_IDLE;
          end else if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            if (rd_r[OB]) begin
              p_r <= p_r + CW'(1);
              i_r <= '0;
            end else if (i_r == CW'(len_r)) begin
              state_r <= S_GROW;
            end else begin
              i_r <= i_r + CW'(1);
            end
          end
        end
        // double the reserved size, up to the capacity, until it covers the block
        S_GROW: begin
          if ((CW+1)'(size_r) <= end_sum && size_r < CW'(CAPACITY)) begin
            size_r <= (size_r << 1) > CW'(CAPACITY) ? CW'(CAPACITY) : (size_r << 1);
          end else begin
            i_r     <= '0;
            state_r <= S_MARK;
          end
        end
        // mark header and data slots, one per cycle
        S_MARK: begin
          if (i_r == CW'(len_r)) begin
            used_r <= used_r + CW'(len_r) + CW'(1);
            fill_r <= AW'(p_r + CW'(1));
            pend_r <= len_r;
            res_r.block_position <= AW'(p_r);
            res_r.used_count     <= used_r + CW'(len_r) + CW'(1);
            res_r.reserved_size  <= size_r;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        // fetch the header slot of a free or read
        S_CHECK: begin
          if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            if (!rd_r[HB]) begin
              res_r.status <= ST_BADPOS;
              res_v_r      <= 1'b1;
              state_r      <= S_IDLE;
            end else if (cmd_r.req == REQ_FREE) begin
              len_r   <= LW'(hlen);
              i_r     <= '0;
              state_r <= S_CLEAR;
            end else begin
              len_r <= (hlen > CW'(MAX_BLOCK)) ? LW'(MAX_BLOCK) : LW'(hlen);
              res_r.block_position <= AW'(p_r);
              if (hlen == '0) begin
                res_v_r <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                i_r     <= CW'(1);
                state_r <= S_EMIT;
              end
            end
          end
        end
        // fetch each block slot, then drop its flags
        S_CLEAR: begin
          if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            if (rd_r[OB] && used_r != '0) used_r <= used_r - CW'(1);
            if (i_r == CW'(len_r)) begin
              state_r <= S_SHRINK;
              i_r     <= (size_r >> 2) + CW'(1);
              p_r     <= '0;
            end else begin
              i_r <= i_r + CW'(1);
            end
          end
        end
        // check the upper three quarters for any occupied slot; halve the size if none is
        S_SHRINK: begin
          if (size_r < CW'(16) || used_r > (size_r >> 2)) begin
            res_r.used_count    <= used_r;
            res_r.reserved_size <= size_r;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            if (rd_r[OB]) begin
              res_r.used_count    <= used_r;
              res_r.reserved_size <= size_r;
              res_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (i_r + CW'(1) >= size_r) begin
              size_r <= size_r >> 1;
              res_r.used_count    <= used_r;
              res_r.reserved_size <= size_r >> 1;
              res_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              i_r <= i_r + CW'(1);
            end
          end
        end
        // one data word per result; wait for the output register to empty
        S_EMIT: begin
          if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else if (!res_v_r || res_ready) begin
            res_r.word_out <= rd_r[DW-1:0];
            res_r.last     <= (i_r == CW'(len_r));
            res_v_r        <= 1'b1;
            rd_v_r         <= 1'b0;
            if (i_r == CW'(len_r)) state_r <= S_IDLE;
            else i_r <= i_r + CW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// ============================================================================
// first_fit_block_allocator: first-fit block allocator top level
// Stream front end, command queue and store engine.
// ============================================================================
// Usage:
//  - Input words on in_* carry req_type in in_tuser and block_length,
//    data_value and position in in_tdata. Results leave on out_*; the last
//    result of a request has out_tlast set.
//  - A four-entry queue takes requests while the engine works, so the
//    sender stalls only when the queue is full.
//  - A data word passes through the queue register and then the engine's
//    result register; the engine takes the next command only once the
//    result has left, so it does not take a new data word while one waits.
//  - Each slot test fetches the slot, then checks it. An allocate tests up
//    to block length plus one slots per candidate position, then doubles
//    the reserved size as needed and marks block length plus one slots. A free
//    fetches the header, clears each block slot and then sweeps up to three
//    quarters of the reserved size. A read fetches the header and then fetches
//    and gives each word in turn, waiting while the receiver stalls.
//  - After reset the engine clears the flags of all 1024 slots in one
//    pass; the queue takes up to four words meanwhile.
//  - When the receiver stalls, the result holds in the output register and
//    the engine waits; the queue keeps taking input until full.
// ============================================================================
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // block_length[5:0], data_value[37:6], position[47:38]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status[1:0], block_position[11:2], word_out[43:12],
                                  // used_count[54:44], reserved_size[65:55]
  output logic        out_tlast
);

  cmd_t  in_cmd, q_cmd;
  logic  q_valid, q_ready;
  res_t  res;

  assign in_cmd.req  = req_t'(in_tuser);
  assign in_cmd.len  = in_tdata[5:0];
  assign in_cmd.data = in_tdata[37:6];
  assign in_cmd.pos  = in_tdata[47:38];

  ffba_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  ffba_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_cmd,
    .res_valid (out_tvalid), .res_ready (out_tready), .res
  );

  assign out_tdata = {6'd0, res.reserved_size, res.used_count, res.word_out,
                      res.block_position, res.status};
  assign out_tlast = res.last;

endmodule

// ===== hdl/ffba_checker.sv =====
// ============================================================================
// ffba_checker: port-level checks for the allocator
// Observe the top-level ports only.
// ============================================================================
module ffba_checker
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_size_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:55] >= 11'(INITIAL_SIZE))
    else $error("reserved size below initial");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'(ST_OK) |-> out_tlast)
    else $error("error result not last");

  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[54:44] <= 11'(CAPACITY))
    else $error("used count out of range");

endmodule

bind first_fit_block_allocator ffba_checker u_chk (.*);

// ===== tb/sv/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb: self-checking bench for the block allocator
// Drives alloc, data, free and read words with random gaps, predicts every
// result word in a behavioral copy of the allocator and checks each one.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int LIMIT_CYCLES = 40_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 160;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // block_length[5:0], data_value[37:6], position[47:38]
  logic [1:0]  in_tuser;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // status, block_position, word_out, used_count, reserved_size
  logic        out_tlast;

  first_fit_block_allocator dut (.*);

  // Behavioral copy of the allocator state.
  logic [DW-1:0] mem_words [CAPACITY];
  bit            slot_busy [CAPACITY];
  bit            slot_head [CAPACITY];
  int unsigned   used_slots, resv_size, fill_at, words_left;
  int            live_heads[$];       // headers of blocks that are allocated
  res_t          pending_results[$];  // predicted words not yet seen

  int  n_items, n_results, n_errors, n_allocs, n_frees, n_reads;
  bit  send_quiet, recv_quiet, hold_req;
  longint unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void push_result(status_t st, logic [AW-1:0] pos, logic [DW-1:0] w,
                                      bit lst);
    res_t r;
    r.status         = st;
    r.block_position = pos;
    r.word_out       = w;
    r.used_count     = CW'(used_slots);
    r.reserved_size  = CW'(resv_size);
    r.last           = lst;
    pending_results.push_back(r);
  endfunction

  // Length held in a header slot, clipped at the top of the store.
  function automatic int unsigned head_length(int unsigned pos);
    int unsigned len;
    len = mem_words[pos][5:0];
    if (pos + len >= CAPACITY) len = CAPACITY - 1 - pos;
    return len;
  endfunction

  function automatic void predict_alloc(int unsigned len);
    int unsigned p;
    bit fits;
    if (words_left != 0 || len == 0 || len > MAX_BLOCK) begin
      push_result(ST_BUSY, '0, '0, 1'b1);
      return;
    end
    // first fit: lowest p with p..p+len all free
    for (p = 0; p + len < CAPACITY; p++) begin
      fits = 1'b1;
      for (int unsigned i = 0; i <= len; i++) if (slot_busy[p + i]) fits = 1'b0;
      if (fits) break;
    end
    if (p + len >= CAPACITY) begin
      push_result(ST_NOSPACE, '0, '0, 1'b1);
      return;
    end
    while (resv_size <= p + len && resv_size < CAPACITY) begin
      resv_size = resv_size * 2;
      if (resv_size > CAPACITY) resv_size = CAPACITY;
    end
    mem_words[p] = DW'(len);
    slot_head[p] = 1'b1;
    for (int unsigned i = 0; i <= len; i++) slot_busy[p + i] = 1'b1;
    used_slots += len + 1;
    fill_at    = p + 1;
    words_left = len;
    live_heads.push_back(p);
    n_allocs++;
    push_result(ST_OK, AW'(p), '0, 1'b1);
  endfunction

  function automatic void predict_data(logic [DW-1:0] value);
    if (words_left == 0 || fill_at >= CAPACITY) begin
      push_result(ST_BUSY, '0, '0, 1'b1);
      return;
    end
    mem_words[fill_at] = value;
    fill_at++;
    words_left--;
    push_result(ST_OK, '0, '0, 1'b1);
  endfunction

  function automatic void predict_free(int unsigned pos);
    int unsigned len;
    bit clear_above;
    if (words_left != 0) begin
      push_result(ST_BUSY, '0, '0, 1'b1);
      return;
    end
    if (pos >= resv_size || !slot_head[pos]) begin
      push_result(ST_BADPOS, '0, '0, 1'b1);
      return;
    end
    len = head_length(pos);
    slot_head[pos] = 1'b0;
    for (int unsigned i = 0; i <= len; i++)
      if (slot_busy[pos + i]) begin
        slot_busy[pos + i] = 1'b0;
        if (used_slots > 0) used_slots--;
      end
    foreach (live_heads[k]) if (live_heads[k] == pos) begin
      live_heads.delete(k);
      break;
    end
    // halve the reserved size when the top three quarters are empty
    if (resv_size >= 16 && used_slots <= resv_size / 4) begin
      clear_above = 1'b1;
      for (int unsigned i = resv_size / 4 + 1; i < resv_size && i < CAPACITY; i++)
        if (slot_busy[i]) clear_above = 1'b0;
      if (clear_above) resv_size = resv_size / 2;
    end
    n_frees++;
    push_result(ST_OK, '0, '0, 1'b1);
  endfunction

  function automatic void predict_read(int unsigned pos);
    int unsigned len;
    if (words_left != 0) begin
      push_result(ST_BUSY, '0, '0, 1'b1);
      return;
    end
    if (pos >= resv_size || !slot_head[pos]) begin
      push_result(ST_BADPOS, '0, '0, 1'b1);
      return;
    end
    len = head_length(pos);
    if (len > MAX_BLOCK) len = MAX_BLOCK;
    n_reads++;
    if (len == 0) begin
      push_result(ST_OK, AW'(pos), '0, 1'b1);
      return;
    end
    for (int unsigned k = 0; k < len; k++)
      push_result(ST_OK, AW'(pos), mem_words[pos + 1 + k], k + 1 == len);
  endfunction

  // Predict one request, then hand the word to the block.
  task automatic send_req(req_t req, logic [LW-1:0] len, logic [DW-1:0] value,
                          logic [AW-1:0] pos);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    case (req)
      REQ_ALLOC: predict_alloc(len);
      REQ_DATA:  predict_data(value);
      REQ_FREE:  predict_free(pos);
      default:   predict_read(pos);
    endcase
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {pos, value, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic send_block(int unsigned len);
    send_req(REQ_ALLOC, LW'(len), $urandom, AW'($urandom));
    if (pending_results[$].status == ST_OK)
      for (int unsigned i = 0; i < len; i++) send_req(REQ_DATA, '0, $urandom, AW'($urandom));
  endtask

  // Receiver: draw a stall per word, honor a long hold when asked.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = recv_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[1:0] !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_tdata[1:0]); n_errors++;
        end
        if (out_tdata[11:2] !== exp_r.block_position) begin
          $error("block_position exp %0d got %0d", exp_r.block_position, out_tdata[11:2]);
          n_errors++;
        end
        if (out_tdata[43:12] !== exp_r.word_out) begin
          $error("word_out exp %h got %h", exp_r.word_out, out_tdata[43:12]); n_errors++;
        end
        if (out_tdata[54:44] !== exp_r.used_count) begin
          $error("used_count exp %0d got %0d", exp_r.used_count, out_tdata[54:44]);
          n_errors++;
        end
        if (out_tdata[65:55] !== exp_r.reserved_size) begin
          $error("reserved_size exp %0d got %0d", exp_r.reserved_size, out_tdata[65:55]);
          n_errors++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_tlast); n_errors++;
        end
      end
    end
  end

  // Extremes, every request kind and each corner named for the allocator.
  task automatic test_directed();
    int unsigned p;
    send_req(REQ_ALLOC, 6'd0, '1, '0);                  // zero length
    send_req(REQ_ALLOC, 6'd33, '0, '1);                 // too long
    send_req(REQ_DATA, '0, 32'h1234_5678, '0);          // stray data word
    send_req(REQ_READ, '0, '0, 10'd1023);               // beyond reserved size
    send_req(REQ_FREE, '0, '0, 10'd3);                  // not a header
    send_req(REQ_ALLOC, 6'd2, '0, '0);
    p = live_heads[$];
    send_req(REQ_READ, '0, '0, AW'(p));                 // busy while filling
    send_req(REQ_DATA, '0, 32'h0000_0000, '0);          // zero is a real value
    send_req(REQ_DATA, '0, 32'h8000_0000, '0);
    send_req(REQ_ALLOC, 6'd32, '1, '1);                 // grows reserved size
    for (int i = 0; i < 32; i++)
      send_req(REQ_DATA, '0, (i % 2) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF, '0);
    send_req(REQ_READ, '0, '0, AW'(p));
    send_req(REQ_READ, '0, '0, AW'(live_heads[$]));
    send_req(REQ_FREE, '0, '0, AW'(p + 1));             // data slot, not header
    send_req(REQ_FREE, '0, '0, AW'(live_heads[$]));     // halves reserved size
    send_req(REQ_READ, '0, '0, AW'(p + 3));             // freed position
    send_req(REQ_FREE, '0, '0, AW'(p));
    send_req(REQ_FREE, '0, '0, AW'(p));                 // double free
  endtask

  // Grow the reserved size step by step, read the top block, then drain it all.
  task automatic test_grow_shrink();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    for (int i = 0; i < 6; i++) send_block(32);
    send_req(REQ_READ, '0, '0, AW'(live_heads[5]));
    while (live_heads.size() > 0)
      send_req(REQ_FREE, '0, '0, AW'(live_heads[$urandom_range(0, live_heads.size() - 1)]));
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // Block the receiver for a long stretch while reads pile up.
  task automatic test_back_pressure();
    send_block(32);
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_req(REQ_READ, '0, '0, AW'(live_heads[$]));
    send_req(REQ_FREE, '0, '0, AW'(live_heads[$]));
  endtask

  task automatic test_random();
    int r, target;
    target = n_items + RANDOM_ITEMS;
    while (n_items < target) begin
      r = $urandom_range(0, 99);
      if (($urandom_range(0, 49)) == 0) send_quiet = !send_quiet;
      if (($urandom_range(0, 49)) == 0) recv_quiet = !recv_quiet;
      if (used_slots > 300 && live_heads.size() > 0) r = 60;
      if (r < 50) begin
        send_block(($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8));
      end else if (r < 55) begin
        // break a fill with a stray request
        send_req(REQ_ALLOC, LW'($urandom_range(1, 8)), $urandom, '0);
        if (words_left > 0) begin
          send_req(req_t'($urandom_range(0, 3) == 3 ? 3 : ($urandom_range(0, 1) ? 0 : 2)),
                   LW'($urandom), $urandom, AW'($urandom));
          while (words_left > 0) send_req(REQ_DATA, LW'($urandom), $urandom, AW'($urandom));
        end
      end else if (r < 70 && live_heads.size() > 0) begin
        send_req(REQ_FREE, LW'($urandom), $urandom,
                 AW'(live_heads[$urandom_range(0, live_heads.size() - 1)]));
      end else if (r < 85 && live_heads.size() > 0) begin
        send_req(REQ_READ, LW'($urandom), $urandom,
                 AW'(live_heads[$urandom_range(0, live_heads.size() - 1)]));
      end else begin
        send_req(req_t'($urandom_range(0, 3)), LW'($urandom), $urandom,
                 AW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 63)));
        while (words_left > 0) send_req(REQ_DATA, LW'($urandom), $urandom, AW'($urandom));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cycle_cnt  = 0;
    hold_req   = 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      mem_words[i] = '0;
      slot_busy[i] = 1'b0;
      slot_head[i] = 1'b0;
    end
    used_slots = 0;
    resv_size  = INITIAL_SIZE;
    fill_at    = 0;
    words_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_pressure();
    test_grow_shrink();
    test_random();

    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d request words and %0d result words", n_items, n_results);
    $display("allocs %0d, frees %0d, reads %0d, with store growth and long stall",
             n_allocs, n_frees, n_reads);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
